[src/celg_pkg.sv]
// ----------------------------------------------------------------------------
// celg_pkg
// Shared types and constants for the cross-entropy loss and gradient core.
// ----------------------------------------------------------------------------
`default_nettype none
package celg_pkg;

  localparam int FRAC_BITS  = 15;
  localparam int ACC_WIDTH  = 48;
  localparam int MANT_FRAC  = 30;
  localparam int GRAD_W     = 31;
  localparam int ERR_W      = 48;
  localparam int DIM_W      = 16;
  localparam int DATA_W     = 16;
  localparam int QDEPTH     = 2;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] GRAD_MAX = 31'h7fff_ffff;

  // One queued item between the front and the back.
  typedef struct packed {
    logic [DATA_W-1:0] target_value;
    logic [DATA_W-1:0] output_prob;
    logic              last_element;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_DIV,
    ST_TERM,
    ST_ERR,
    ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

[src/celg_front.sv]
// ----------------------------------------------------------------------------
// celg_front
// Input stage and two-entry queue that decouples input from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module celg_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  celg_pkg::item_t in_item,
  output logic                q_valid,
  input  wire                 q_pop,
  output celg_pkg::item_t     q_item
);
  import celg_pkg::*;

  item_t      mem [QDEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  // A transfer is taken while the queue has room.
  assign in_stall = (count == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

[src/celg_back.sv]
// ----------------------------------------------------------------------------
// celg_back
// Sequencer that computes log, gradient division, accumulation, batch-error division and output.
// ----------------------------------------------------------------------------
`default_nettype none
module celg_back (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      q_valid,
  output logic                     q_pop,
  input  wire  celg_pkg::item_t    q_item,
  input  wire  [celg_pkg::DIM_W-1:0] vector_dim,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [celg_pkg::GRAD_W-1:0] gradient,
  output logic                     zero_output,
  output logic                     error_valid,
  output logic signed [celg_pkg::ERR_W-1:0] error_value
);
  import celg_pkg::*;

  back_state_t state, state_next;
  item_t       cur;
  logic [4:0]  step;
  logic [31:0] z;           // mantissa, 30 fraction bits, value < 2
  logic [FRAC_BITS-1:0] frac;
  logic [3:0]  p;
  logic signed [31:0] ln_val;
  // gradient restoring divider
  logic [31:0] rem;
  logic [31:0] quo;
  logic [5:0]  dstep;
  // error divider
  logic [ACC_WIDTH-1:0] emag, erem;
  logic                 eneg;
  logic [6:0]           estep;
  logic signed [ACC_WIDTH-1:0] error_sum;
  logic signed [63:0] prod;
  logic [63:0] zsq;
  logic [3:0]  lead;
  logic [15:0] o_eff;
  logic [32:0] rsub;
  logic [ACC_WIDTH:0] esub;
  logic [15:0] dv;
  logic signed [ACC_WIDTH+1:0] sum_wide;
  logic signed [ACC_WIDTH-1:0] term;

  localparam logic signed [ACC_WIDTH+1:0] ACC_MAX = (ACC_WIDTH+2)'(
    (64'sd1 <<< (ACC_WIDTH-1)) - 1);
  localparam logic signed [ACC_WIDTH+1:0] ACC_MIN = -ACC_MAX - 1;

  // Leading-one position of the (clamped) output probability.
  always_comb begin
    o_eff = (cur.output_prob == '0) ? 16'd1 : cur.output_prob;
    lead  = 4'd0;
    for (int i = 0; i < 16; i++) if (o_eff[i]) lead = 4'(i);
  end

  assign zsq  = 64'(z) * 64'(z);
  assign rsub = {rem, quo[31]} - {1'b0, 16'd0, cur.output_prob};
  assign dv   = (vector_dim == '0) ? 16'd1 : vector_dim;
  assign esub = {erem, emag[ACC_WIDTH-1]} - (ACC_WIDTH+1)'(dv);
  assign term = ACC_WIDTH'((prod + 64'sd16384) >>> FRAC_BITS);
  assign sum_wide = (ACC_WIDTH+2)'(error_sum) + (ACC_WIDTH+2)'(term);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_LOG;
      ST_LOG:  if (step == 5'(FRAC_BITS + 1)) state_next = ST_DIV;
      ST_DIV:  if (dstep == 6'd32) state_next = ST_TERM;
      ST_TERM: if (step == 5'd1) state_next = cur.last_element ? ST_ERR : ST_OUT;
      ST_ERR:  if (estep == 7'(ACC_WIDTH + 1)) state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (state == ST_TERM && step == 5'd1) begin
      if (sum_wide > ACC_MAX)      error_sum <= ACC_WIDTH'(ACC_MAX);
      else if (sum_wide < ACC_MIN) error_sum <= ACC_WIDTH'(ACC_MIN);
      else                         error_sum <= ACC_WIDTH'(sum_wide);
    end else if (state == ST_ERR && estep == 7'(ACC_WIDTH + 1)) begin
      error_sum <= '0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur  <= q_item;
        step <= '0;
      end
      ST_LOG: begin
        if (step == 5'd0) begin
          p    <= lead;
          z    <= 32'(o_eff) << (5'd30 - 5'(lead));
          frac <= '0;
          step <= 5'd1;
        end else if (step <= 5'(FRAC_BITS)) begin
          if (zsq[63:30] >= 34'(2) << 30) begin
            z <= zsq[62:31];
            frac[FRAC_BITS - 32'(step)] <= 1'b1;
          end else begin
            z <= zsq[61:30];
          end
          step <= step + 5'd1;
        end else begin
          // Log2 value, then ready the gradient divider.
          ln_val <= 32'(($signed({1'b0, p}) - 6'sd15)) * 32'sd32768 + 32'(frac);
          rem    <= '0;
          quo    <= 32'(cur.target_value) << FRAC_BITS;
          dstep  <= '0;
        end
      end
      ST_DIV: begin
        if (dstep == 6'd0) begin
          prod <= 64'(ln_val) * 64'(LN2_Q30) + (64'sd1 <<< 29);
        end else if (dstep == 6'd1) begin
          prod <= prod >>> MANT_FRAC;
        end
        if (dstep < 6'd32) begin
          if (!rsub[32] && cur.output_prob != '0) begin
            rem <= rsub[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
          dstep <= dstep + 6'd1;
        end else begin
          prod <= signed'(prod[31:0]) * $signed({1'b0, cur.target_value});
          step <= '0;
        end
      end
      ST_TERM: begin
        step <= 5'd1;
        emag <= '0;
        erem <= '0;
        estep <= '0;
      end
      ST_ERR: begin
        if (estep == 7'd0) begin
          eneg <= error_sum[ACC_WIDTH-1];
          emag <= error_sum[ACC_WIDTH-1] ? ACC_WIDTH'(-error_sum) : error_sum;
          estep <= 7'd1;
        end else if (estep <= 7'(ACC_WIDTH)) begin
          if (!esub[ACC_WIDTH]) begin
            erem <= esub[ACC_WIDTH-1:0];
            emag <= {emag[ACC_WIDTH-2:0], 1'b1};
          end else begin
            erem <= {erem[ACC_WIDTH-2:0], emag[ACC_WIDTH-1]};
            emag <= {emag[ACC_WIDTH-2:0], 1'b0};
          end
          estep <= estep + 7'd1;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // Result fields, held through a stalled transfer.
  always_comb begin
    gradient    = (cur.output_prob == '0) ? '0 :
                  ((quo > 32'(GRAD_MAX)) ? GRAD_MAX : quo[30:0]);
    zero_output = (cur.output_prob == '0);
    error_valid = cur.last_element;
    error_value = cur.last_element ?
                  (eneg ? ERR_W'(-emag) : ERR_W'(emag)) : '0;
  end
endmodule
`default_nettype wire

[src/cross_entropy_loss_grad_core.sv]
// ----------------------------------------------------------------------------
// cross_entropy_loss_grad_core
// Cross-entropy loss term accumulation and per-element gradient.
// ----------------------------------------------------------------------------
// Each item goes from the queue pop through these steps to the result: a load,
// the squaring log (setup, 15 squarings, combine), the 32-step restoring
// divider for the gradient, which also forms the log term, a round and
// accumulate step, on the item marked last the 48-step batch-error divider,
// and the result, which holds while the result side stalls. A two-entry queue
// lets the input side accept items while the back end works.
`default_nettype none
module cross_entropy_loss_grad_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [15:0] target_value,
  input  wire  [15:0] output_prob,
  input  wire         last_element,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [30:0] gradient,
  output logic        zero_output,
  output logic        error_valid,
  output logic signed [47:0] error_value
);
  import celg_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_pop;
  logic [DIM_W-1:0] vector_dim;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst)         vector_dim <= 16'd1;
    else if (cfg_we) vector_dim <= cfg_data;
  end

  assign in_item = '{target_value: target_value, output_prob: output_prob,
                     last_element: last_element};

  celg_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .q_valid, .q_pop, .q_item
  );

  celg_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_item, .vector_dim,
    .out_valid, .out_stall, .gradient, .zero_output, .error_valid, .error_value
  );

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gradient))
    else $error("result changed under stall");

  // A zero output always gives a zero gradient.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_output |-> gradient == '0)
    else $error("zero output with nonzero gradient");
endmodule
`default_nettype wire
